// ----- sv/tam_pkg.sv -----
// Shared types and constants for the tilt arm motion controller.
package tam_pkg;

  localparam int unsigned SampleBits = 12;
  localparam int unsigned SpeedBits  = 7;
  localparam int unsigned VelBits    = 8;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgBits    = 12;

  localparam logic [SpeedBits-1:0] SpeedMax = SpeedBits'(100);
  localparam logic signed [VelBits-1:0] VelFull = VelBits'(100);

  typedef enum logic [2:0] {
    ModeIdle     = 3'd0,
    ModeForward  = 3'd1,
    ModeBackward = 3'd2,
    ModeUp       = 3'd3,
    ModeReturn   = 3'd4,
    ModeStopping = 3'd5
  } mode_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgForwardLimit   = 3'd0,
    CfgBackwardLimit  = 3'd1,
    CfgUpTarget       = 3'd2,
    CfgReturnLiftLim  = 3'd3,
    CfgReturnLowLim   = 3'd4,
    CfgReturnHighLim  = 3'd5,
    CfgForwardSpeed   = 3'd6,
    CfgBackwardSpeed  = 3'd7
  } cfg_idx_e;

  // Register file contents, speeds already limited to full scale.
  typedef struct packed {
    logic [SampleBits-1:0] forward_limit;
    logic [SampleBits-1:0] backward_limit;
    logic [SampleBits-1:0] up_target;
    logic [SampleBits-1:0] return_lift_limit;
    logic [SampleBits-1:0] return_low_limit;
    logic [SampleBits-1:0] return_high_limit;
    logic [SpeedBits-1:0]  forward_speed;
    logic [SpeedBits-1:0]  backward_speed;
  } cfg_t;

  typedef struct packed {
    logic                  forward_button;
    logic                  backward_button;
    logic                  go_up_button;
    logic                  return_button;
    logic [SampleBits-1:0] tilt_position;
    logic [SampleBits-1:0] lift_position;
    logic                  motor_stopped;
  } tick_t;

  typedef struct packed {
    mode_e                    mode;
    logic signed [VelBits-1:0] velocity;
    logic                     locked;
  } ctrl_state_t;

endpackage

// ----- sv/tam_cfg_regs.sv -----
// Configuration register file with speed saturation.
module tam_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tam_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [tam_pkg::CfgBits-1:0]    cfg_data_i,
  output tam_pkg::cfg_t                 cfg_o
);
  import tam_pkg::*;

  logic [SampleBits-1:0] fwd_lim_q, bwd_lim_q, up_tgt_q;
  logic [SampleBits-1:0] ret_lift_q, ret_low_q, ret_high_q;
  logic [SpeedBits-1:0]  fwd_spd_q, bwd_spd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_lim_q  <= SampleBits'(2150);
      bwd_lim_q  <= SampleBits'(1430);
      up_tgt_q   <= SampleBits'(1850);
      ret_lift_q <= SampleBits'(1250);
      ret_low_q  <= SampleBits'(1520);
      ret_high_q <= SampleBits'(1870);
      fwd_spd_q  <= SpeedBits'(35);
      bwd_spd_q  <= SpeedBits'(75);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgForwardLimit:  fwd_lim_q  <= cfg_data_i[SampleBits-1:0];
        CfgBackwardLimit: bwd_lim_q  <= cfg_data_i[SampleBits-1:0];
        CfgUpTarget:      up_tgt_q   <= cfg_data_i[SampleBits-1:0];
        CfgReturnLiftLim: ret_lift_q <= cfg_data_i[SampleBits-1:0];
        CfgReturnLowLim:  ret_low_q  <= cfg_data_i[SampleBits-1:0];
        CfgReturnHighLim: ret_high_q <= cfg_data_i[SampleBits-1:0];
        CfgForwardSpeed:  fwd_spd_q  <= cfg_data_i[SpeedBits-1:0];
        CfgBackwardSpeed: bwd_spd_q  <= cfg_data_i[SpeedBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.forward_limit     = fwd_lim_q;
    cfg_o.backward_limit    = bwd_lim_q;
    cfg_o.up_target         = up_tgt_q;
    cfg_o.return_lift_limit = ret_lift_q;
    cfg_o.return_low_limit  = ret_low_q;
    cfg_o.return_high_limit = ret_high_q;
    cfg_o.forward_speed     = (fwd_spd_q > SpeedMax) ? SpeedMax : fwd_spd_q;
    cfg_o.backward_speed    = (bwd_spd_q > SpeedMax) ? SpeedMax : bwd_spd_q;
  end

endmodule

// ----- sv/tam_step.sv -----
// Combinational mode and velocity update for one control tick.
module tam_step (
  input  tam_pkg::tick_t       tick_i,
  input  tam_pkg::cfg_t        cfg_i,
  input  tam_pkg::ctrl_state_t state_i,
  output tam_pkg::ctrl_state_t state_o
);
  import tam_pkg::*;

  mode_e                     mode;
  logic signed [VelBits-1:0] vel;
  logic                      lock;
  logic                      ret_far;

  assign ret_far = ((tick_i.lift_position < cfg_i.return_lift_limit) &&
                    (tick_i.tilt_position > cfg_i.return_low_limit)) ||
                   (tick_i.tilt_position > cfg_i.return_high_limit);

  always_comb begin
    mode = state_i.mode;
    vel  = state_i.velocity;
    lock = state_i.locked;

    // Button rules are applied in priority order; later ones win.
    if (tick_i.forward_button) mode = ModeForward;
    else if (mode == ModeForward) mode = ModeStopping;

    if (tick_i.backward_button) mode = ModeBackward;
    else if (mode == ModeBackward) mode = ModeStopping;

    if (tick_i.go_up_button) mode = ModeUp;
    else if (mode == ModeUp && tick_i.motor_stopped) mode = ModeStopping;

    if (mode == ModeForward && tick_i.tilt_position > cfg_i.forward_limit) begin
      mode = ModeStopping;
    end
    if (mode == ModeBackward && tick_i.tilt_position <= cfg_i.backward_limit) begin
      mode = ModeStopping;
    end

    case (mode)
      ModeForward: begin
        vel  = VelBits'(cfg_i.forward_speed);
        lock = 1'b0;
      end
      ModeBackward: begin
        vel  = -$signed(VelBits'(cfg_i.backward_speed));
        lock = 1'b0;
      end
      ModeUp: begin
        lock = 1'b1;
        if (tick_i.tilt_position < cfg_i.up_target) begin
          vel = VelFull;
        end else begin
          vel  = '0;
          mode = ModeStopping;
        end
      end
      ModeReturn: begin
        if (ret_far) vel = -VelFull;
      end
      ModeStopping: begin
        vel  = '0;
        mode = ModeIdle;
      end
      default: ;
    endcase

    if (tick_i.return_button) mode = ModeReturn;
    else if (mode == ModeReturn && tick_i.motor_stopped) mode = ModeStopping;

    state_o.mode     = mode;
    state_o.velocity = vel;
    state_o.locked   = lock;
  end

endmodule

// ----- sv/tilt_arm_motion_controller_core.sv -----
// Top level of the tilt arm motion controller: input register, step logic, result register.
// A word accepted into the input register moves into the result register once that register
// is free (out_valid_q low or m_axis_tready high), and is shown on m_axis_tdata from then on.
// Throughput: one word per cycle while the receiver takes results; m_axis_tready low backs it up.
// The controller state doubles as the result register, since each result is that state.
// Reset: rst_ni clears the mode to idle, velocity and lock to zero, and loads register defaults.
module tilt_arm_motion_controller_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tam_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [tam_pkg::CfgBits-1:0]    cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: forward_button, backward_button, go_up_button, return_button,
  // tilt_position[15:4], lift_position[27:16], motor_stopped[28], zero fill.
  input  logic [31:0]                   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: velocity_command[7:0], tray_locked[8], mode_now[11:9], zero fill.
  output logic [15:0]                   m_axis_tdata
);
  import tam_pkg::*;

  cfg_t        cfg;
  tick_t       tick_q;
  ctrl_state_t state_q, state_d;
  logic        in_valid_q, out_valid_q;
  logic        out_free, advance;

  tam_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tam_step u_step (
    .tick_i (tick_q),
    .cfg_i  (cfg),
    .state_i(state_q),
    .state_o(state_d)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      tick_q.forward_button  <= s_axis_tdata[0];
      tick_q.backward_button <= s_axis_tdata[1];
      tick_q.go_up_button    <= s_axis_tdata[2];
      tick_q.return_button   <= s_axis_tdata[3];
      tick_q.tilt_position   <= s_axis_tdata[4 +: SampleBits];
      tick_q.lift_position   <= s_axis_tdata[16 +: SampleBits];
      tick_q.motor_stopped   <= s_axis_tdata[28];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q      <= 1'b0;
      state_q.mode     <= ModeIdle;
      state_q.velocity <= '0;
      state_q.locked   <= 1'b0;
    end else begin
      if (out_free) out_valid_q <= in_valid_q;
      if (advance) state_q <= state_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, state_q.mode, state_q.locked, state_q.velocity};

  // The lock is only ever set by go-up, which leaves up, stopping or return.
  a_lock_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q.locked) |-> (state_q.mode == ModeUp || state_q.mode == ModeStopping ||
                               state_q.mode == ModeReturn))
    else $error("tray lock set outside go-up");

  a_vel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($signed(state_q.velocity) >= -VelFull) && ($signed(state_q.velocity) <= VelFull))
    else $error("velocity command out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a full pipeline");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("controller state changed without a word");

endmodule

// ----- tb/sv/tilt_arm_motion_controller_core_test.sv -----
// Self-checking stream testbench for the tilt arm motion controller core.
`timescale 1ns / 100ps

module tilt_arm_motion_controller_core_test;
  import tam_pkg::*;

  localparam int QuietLimit = 3000;
  localparam int HoldCycles = 120;
  localparam int ErrShown   = 10;

  localparam logic [3:0] BtnNone = 4'b0000;
  localparam logic [3:0] BtnFwd  = 4'b0001;
  localparam logic [3:0] BtnBwd  = 4'b0010;
  localparam logic [3:0] BtnUp   = 4'b0100;
  localparam logic [3:0] BtnRet  = 4'b1000;
  localparam logic [3:0] BtnAll  = 4'b1111;

  logic                  clk_i = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  logic [CfgBits-1:0]    cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;

  logic [31:0]   pending_ticks[$];
  ctrl_state_t   due_states[$];
  ctrl_state_t   arm_state;
  logic [11:0]   cfg_shadow[8];
  logic          in_fire = 1'b0;
  int            n_queued = 0;
  int            n_taken = 0;
  int            n_errors = 0;
  int            quiet_cycles = 0;
  int            idle_pct = 35;
  bit            hold_req = 1'b0;
  int            hold_left = 0;

  tilt_arm_motion_controller_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Input word from bit 0: four buttons, tilt, lift, motor stopped.
  function automatic logic [31:0] tick_word(logic [3:0] btns, logic [11:0] tilt,
                                            logic [11:0] lift, logic stopped);
    return {3'b000, stopped, lift, tilt, btns};
  endfunction

  function automatic logic signed [7:0] limited_speed(logic [11:0] raw);
    logic [SpeedBits-1:0] s;
    s = raw[SpeedBits-1:0];
    if (s > SpeedMax) s = SpeedMax;
    return $signed({1'b0, s});
  endfunction

  // One control tick: button rules, limit checks, mode actions, then the return rule.
  function automatic ctrl_state_t next_arm_state(ctrl_state_t cur, logic [31:0] w);
    ctrl_state_t nxt;
    logic        fwd, bwd, upb, ret, stopped;
    logic [11:0] tilt, lift;
    fwd = w[0];
    bwd = w[1];
    upb = w[2];
    ret = w[3];
    tilt = w[15:4];
    lift = w[27:16];
    stopped = w[28];
    nxt = cur;

    if (fwd) nxt.mode = ModeForward;
    else if (nxt.mode == ModeForward) nxt.mode = ModeStopping;
    if (bwd) nxt.mode = ModeBackward;
    else if (nxt.mode == ModeBackward) nxt.mode = ModeStopping;
    if (upb) nxt.mode = ModeUp;
    else if (nxt.mode == ModeUp && stopped) nxt.mode = ModeStopping;

    if (nxt.mode == ModeForward && tilt > cfg_shadow[CfgForwardLimit])
      nxt.mode = ModeStopping;
    if (nxt.mode == ModeBackward && tilt <= cfg_shadow[CfgBackwardLimit])
      nxt.mode = ModeStopping;

    case (nxt.mode)
      ModeForward: begin
        nxt.velocity = limited_speed(cfg_shadow[CfgForwardSpeed]);
        nxt.locked = 1'b0;
      end
      ModeBackward: begin
        nxt.velocity = -limited_speed(cfg_shadow[CfgBackwardSpeed]);
        nxt.locked = 1'b0;
      end
      ModeUp: begin
        nxt.locked = 1'b1;
        if (tilt < cfg_shadow[CfgUpTarget]) begin
          nxt.velocity = VelFull;
        end else begin
          nxt.velocity = '0;
          nxt.mode = ModeStopping;
        end
      end
      ModeReturn: begin
        if ((lift < cfg_shadow[CfgReturnLiftLim] && tilt > cfg_shadow[CfgReturnLowLim]) ||
            tilt > cfg_shadow[CfgReturnHighLim])
          nxt.velocity = -VelFull;
      end
      ModeStopping: begin
        nxt.velocity = '0;
        nxt.mode = ModeIdle;
      end
      default: ;
    endcase

    if (ret) nxt.mode = ModeReturn;
    else if (nxt.mode == ModeReturn && stopped) nxt.mode = ModeStopping;
    return nxt;
  endfunction

  task automatic flag_error(string what);
    n_errors++;
    if (n_errors <= ErrShown) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  // Sender: a word stays on the bus until it is taken.
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_fire) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= idle_pct) begin
        s_axis_tdata <= pending_ticks.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver, with an optional long hold-off to back the block up.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    ctrl_state_t want;
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      if (due_states.size() == 0) begin
        flag_error($sformatf("result word %h with nothing outstanding", m_axis_tdata));
      end else begin
        want = due_states.pop_front();
        if (m_axis_tdata[7:0] !== want.velocity || m_axis_tdata[8] !== want.locked ||
            m_axis_tdata[11:9] !== want.mode)
          flag_error($sformatf("vel %0d lock %0d mode %0d, expected vel %0d lock %0d mode %0d",
                               $signed(m_axis_tdata[7:0]), m_axis_tdata[8], m_axis_tdata[11:9],
                               want.velocity, want.locked, want.mode));
      end
    end
    if (rst_n && s_axis_tvalid && s_axis_tready) begin
      arm_state = next_arm_state(arm_state, s_axis_tdata);
      due_states.push_back(arm_state);
      n_taken++;
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic offer(logic [31:0] w);
    pending_ticks.push_back(w);
    n_queued++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [11:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    cfg_shadow[idx] = (idx >= CfgForwardSpeed) ? (val & 12'h07F) : val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (n_taken != n_queued || due_states.size() != 0) @(posedge clk_i);
  endtask

  // Button runs: a press held for a few ticks, then a release, with tilt ramping
  // around one of the thresholds. A share of the words is pure noise.
  task automatic queue_runs(int n_items);
    int          count;
    int          kind;
    int          press_len;
    int          rel_len;
    int          slope;
    logic [3:0]  btns;
    logic [11:0] tilt;
    logic [11:0] lift;
    count = 0;
    while (count < n_items) begin
      kind = $urandom_range(9);
      if (kind >= 8) begin
        offer(tick_word(4'($urandom), 12'($urandom), 12'($urandom), 1'($urandom)));
        count++;
      end else begin
        press_len = $urandom_range(1, 8);
        rel_len = $urandom_range(1, 6);
        slope = $urandom_range(40) - 20;
        tilt = $urandom_range(3) == 0 ? 12'($urandom)
             : cfg_shadow[3'($urandom_range(5))] + 12'($urandom_range(16)) - 12'd8;
        lift = $urandom_range(1) ? 12'($urandom)
             : cfg_shadow[CfgReturnLiftLim] + 12'($urandom_range(8)) - 12'd4;
        for (int k = 0; k < press_len + rel_len; k++) begin
          btns = (k < press_len) ? (BtnFwd << (kind % 4)) : BtnNone;
          if ($urandom_range(7) == 0) btns ^= (BtnFwd << $urandom_range(3));
          offer(tick_word(btns, tilt, lift, $urandom_range(3) == 0));
          tilt = tilt + 12'(slope);
          count++;
        end
      end
    end
  endtask

  task automatic random_config();
    for (int r = 0; r < 6; r++) write_reg(cfg_idx_e'(r), 12'($urandom));
    write_reg(CfgForwardSpeed, 12'($urandom_range(127)));
    write_reg(CfgBackwardSpeed, 12'($urandom_range(127)));
  endtask

  initial begin
    cfg_shadow = '{12'd2150, 12'd1430, 12'd1850, 12'd1250, 12'd1520, 12'd1870, 12'd35, 12'd75};
    arm_state = '{mode: ModeIdle, velocity: '0, locked: 1'b0};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // Directed ticks against the reset settings.
    offer(tick_word(BtnNone, 12'd0, 12'd0, 1'b0));
    offer(tick_word(BtnFwd, 12'd2000, 12'd100, 1'b0));
    offer(tick_word(BtnFwd, 12'd2150, 12'd100, 1'b0));
    offer(tick_word(BtnFwd, 12'd2151, 12'd100, 1'b0));
    offer(tick_word(BtnNone, 12'd2000, 12'd100, 1'b0));
    offer(tick_word(BtnBwd, 12'd1431, 12'd100, 1'b0));
    offer(tick_word(BtnBwd, 12'd1430, 12'd100, 1'b0));
    offer(tick_word(BtnNone, 12'd1500, 12'd100, 1'b0));
    offer(tick_word(BtnUp, 12'd0, 12'd100, 1'b1));
    offer(tick_word(BtnNone, 12'd1849, 12'd100, 1'b0));
    offer(tick_word(BtnUp, 12'd1850, 12'd100, 1'b0));
    offer(tick_word(BtnUp, 12'd1000, 12'd100, 1'b0));
    offer(tick_word(BtnNone, 12'd1000, 12'd100, 1'b1));
    offer(tick_word(BtnRet, 12'd1521, 12'd0, 1'b1));
    offer(tick_word(BtnNone, 12'd1521, 12'd1249, 1'b0));
    offer(tick_word(BtnNone, 12'd1520, 12'd1249, 1'b0));
    offer(tick_word(BtnNone, 12'd1871, 12'd4095, 1'b0));
    offer(tick_word(BtnNone, 12'd1870, 12'd4095, 1'b0));
    offer(tick_word(BtnNone, 12'd1000, 12'd1250, 1'b1));
    offer(tick_word(BtnNone, 12'd1000, 12'd0, 1'b0));
    // Go up and return on the same stopped sample.
    offer(tick_word(BtnUp | BtnRet, 12'd100, 12'd100, 1'b1));
    offer(tick_word(BtnNone, 12'd4095, 12'd0, 1'b1));
    offer(tick_word(BtnAll, 12'd4095, 12'd4095, 1'b1));
    offer(tick_word(BtnNone, 12'd4095, 12'd4095, 1'b1));
    offer(tick_word(BtnNone, 12'd0, 12'd0, 1'b0));
    drain();

    queue_runs(200);
    drain();

    for (int r = 0; r < 8; r++) write_reg(cfg_idx_e'(r), 12'd0);
    queue_runs(200);
    drain();

    for (int r = 0; r < 6; r++) write_reg(cfg_idx_e'(r), 12'hFFF);
    write_reg(CfgForwardSpeed, 12'd127);
    write_reg(CfgBackwardSpeed, 12'd127);
    queue_runs(200);
    drain();

    random_config();
    write_reg(CfgForwardSpeed, 12'd100);
    write_reg(CfgBackwardSpeed, 12'd101);
    queue_runs(200);
    drain();

    // No idling on either side, and one long receiver hold-off meanwhile.
    idle_pct = 0;
    queue_runs(250);
    @(posedge clk_i);
    hold_req = 1'b1;
    drain();
    idle_pct = 35;

    repeat (3) begin
      random_config();
      queue_runs(150);
      drain();
    end

    write_reg(CfgForwardLimit, 12'd2150);
    write_reg(CfgBackwardLimit, 12'd1430);
    write_reg(CfgUpTarget, 12'd1850);
    write_reg(CfgReturnLiftLim, 12'd1250);
    write_reg(CfgReturnLowLim, 12'd1520);
    write_reg(CfgReturnHighLim, 12'd1870);
    write_reg(CfgForwardSpeed, 12'd35);
    write_reg(CfgBackwardSpeed, 12'd75);
    queue_runs(200);
    drain();

    repeat (10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
